// ===== hdl/pnrf_pkg.sv =====
// Package with the types, constants and helper functions of the Newton root finder.
`default_nettype none

package pnrf_pkg;

    localparam int unsigned MAX_DEGREE_DEF = 63;
    localparam int unsigned QW   = 48;
    localparam int unsigned FW   = 24;
    localparam int unsigned EPSW = 25;
    localparam int unsigned ITW  = 12;
    localparam int unsigned DEGW = 6;
    localparam int unsigned IDXW = 6;

    localparam logic [EPSW-1:0] EPS_RESET = 25'd17;
    localparam logic [ITW-1:0]  ITER_RESET = 12'd1001;
    localparam logic [DEGW-1:0] DEG_RESET = '0;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEGREE  = 2'd0;
    localparam logic [1:0] REG_EPSILON = 2'd1;
    localparam logic [1:0] REG_MAXITER = 2'd2;

    // Input modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_SOLVE = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_ZERO_DER  = 2'd2;

    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef struct packed {
        logic                 mode;
        logic [IDXW-1:0]      coef_index;
        logic signed [QW-1:0] coef_value;
        logic signed [QW-1:0] x_start;
    } t_in_beat;

    typedef struct packed {
        logic signed [QW-1:0] root;
        logic [ITW-1:0]       iterations;
        logic [1:0]           status;
    } t_out_beat;

    // Convert an unsigned magnitude and sign into a saturated Q24.24 value.
    function automatic logic signed [QW-1:0] from_mag(input logic [QW:0] m, input logic neg);
        logic signed [QW-1:0] r;
        if (neg) begin
            if (m >= {2'b01, {(QW-1){1'b0}}}) r = Q_MIN;
            else r = -$signed(m[QW-1:0]);
        end else begin
            if (m > {2'b00, {(QW-1){1'b1}}}) r = Q_MAX;
            else r = $signed(m[QW-1:0]);
        end
        return r;
    endfunction

    // Magnitude of a signed Q24.24 value.
    function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] v);
        return v[QW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pnrf_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module pnrf_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/pnrf_mul.sv =====
// Sequential 48x48 Q24.24 multiplier: 24x24 partial products over several cycles.
`default_nettype none

module pnrf_mul (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [pnrf_pkg::QW-1:0]     i_a,
    input  wire logic signed [pnrf_pkg::QW-1:0]     i_b,
    output logic                                    o_done,
    output logic signed [pnrf_pkg::QW-1:0]          o_p
);

    typedef enum logic [2:0] {S_IDLE, S_HH, S_AHBL, S_ALBH, S_ALBL, S_FIN} t_state;

    t_state r_state;
    logic [23:0] r_ah, r_al, r_bh, r_bl;
    logic        r_neg;
    logic [47:0] r_hh;
    logic [48:0] r_acc;
    logic [23:0] mul_x, mul_y;
    logic [47:0] prod;

    // One shared 24x24 multiplier.
    always_comb begin
        unique case (r_state)
            S_HH:    begin mul_x = r_ah; mul_y = r_bh; end
            S_AHBL:  begin mul_x = r_ah; mul_y = r_bl; end
            S_ALBH:  begin mul_x = r_al; mul_y = r_bh; end
            S_ALBL:  begin mul_x = r_al; mul_y = r_bl; end
            default: begin mul_x = r_ah; mul_y = r_bh; end
        endcase
        prod = mul_x * mul_y;
    end

    // Sequencer, accumulation and saturation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        {r_ah, r_al} <= pnrf_pkg::mag(i_a);
                        {r_bh, r_bl} <= pnrf_pkg::mag(i_b);
                        r_neg   <= i_a[47] ^ i_b[47];
                        r_state <= S_HH;
                    end
                end
                S_HH: begin
                    r_hh    <= prod;
                    r_acc   <= {1'b0, prod[23:0], 24'd0};
                    r_state <= S_AHBL;
                end
                S_AHBL: begin
                    r_acc   <= r_acc + {1'b0, prod};
                    r_state <= S_ALBH;
                end
                S_ALBH: begin
                    r_acc   <= r_acc + {1'b0, prod};
                    r_state <= S_ALBL;
                end
                S_ALBL: begin
                    r_acc   <= r_acc + {25'd0, prod[47:24]};
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_hh >= 48'h800000) begin
                        o_p <= pnrf_pkg::from_mag({1'b1, 48'd0}, r_neg);
                    end else begin
                        o_p <= pnrf_pkg::from_mag(r_acc, r_neg);
                    end
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pnrf_div.sv =====
// Restoring Q24.24 divider, one quotient bit per cycle.
`default_nettype none

module pnrf_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic signed [pnrf_pkg::QW-1:0] i_a,
    input  wire logic signed [pnrf_pkg::QW-1:0] i_b,
    output logic                                o_done,
    output logic signed [pnrf_pkg::QW-1:0]      o_q
);

    // Quotient of (|a| << 24) / |b| takes 72 bits; magnitudes of 2^47 and above saturate.
    localparam int unsigned NW = 72;

    logic          r_busy;
    logic [6:0]    r_cnt;
    logic [NW-1:0] r_num;
    logic [48:0]   r_rem;
    logic [47:0]   r_den;
    logic [48:0]   r_q;
    logic          r_neg;
    logic          r_ovf;
    logic [48:0]   rem_sh;

    assign rem_sh = {r_rem[47:0], r_num[NW-1]};

    // One compare and subtract each cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_num  <= {pnrf_pkg::mag(i_a), 24'd0};
                    r_den  <= pnrf_pkg::mag(i_b);
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_ovf  <= 1'b0;
                    r_neg  <= i_a[47] ^ i_b[47];
                    r_cnt  <= 7'd0;
                    r_busy <= 1'b1;
                end
            end else if (r_cnt == 7'(NW)) begin
                o_q    <= pnrf_pkg::from_mag(r_ovf ? {1'b1, 48'd0} : r_q, r_neg);
                o_done <= 1'b1;
                r_busy <= 1'b0;
            end else begin
                r_num <= {r_num[NW-2:0], 1'b0};
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= rem_sh - {1'b0, r_den};
                    r_q   <= {r_q[47:0], 1'b1};
                    if (r_q[48]) r_ovf <= 1'b1;
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[47:0], 1'b0};
                    if (r_q[48]) r_ovf <= 1'b1;
                end
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/polynomial_newton_root_finder.sv =====
// Top level of the Newton-Raphson polynomial root finder.
// A load beat writes one coefficient. A solve beat runs Newton iterations;
// each iteration walks the coefficient store twice (derivative, then value).
// The first coefficient of a pass goes through read, read wait, term and add;
// every later one also waits on the shared multiplier between term and add.
// The bit-serial divider then forms the Newton step. Busy stays high until
// the result beat, which is shown for one cycle with o_done and cannot be
// held off by the receiver.
`default_nettype none

module polynomial_newton_root_finder #(
    parameter int unsigned MAX_DEGREE = pnrf_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire pnrf_pkg::t_in_beat            i_in,
    output logic                               o_done,
    output pnrf_pkg::t_out_beat                o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [pnrf_pkg::EPSW-1:0]     i_cfg_data
);

    localparam int unsigned DEPTH = MAX_DEGREE + 1;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned NW    = $clog2(MAX_DEGREE + 1) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_ITER, S_RD, S_RDW, S_TERM, S_MUL, S_ADD,
        S_DIV, S_DIVW, S_UPD, S_OUT
    } t_state;

    t_state r_state;
    logic [pnrf_pkg::DEGW-1:0] r_degree;
    logic [pnrf_pkg::EPSW-1:0] r_eps;
    logic [pnrf_pkg::ITW-1:0]  r_maxit;
    logic [NW-1:0]             r_n;
    logic [NW-1:0]             r_i;
    logic                      r_slope;
    logic signed [47:0]        r_x, r_p, r_d, r_term;
    logic [pnrf_pkg::ITW-1:0]  r_cnt;
    logic [1:0]                r_status;
    logic                      r_mstart, r_dstart;

    logic [47:0]               ram_rdata;
    logic                      mul_done, div_done;
    logic signed [47:0]        mul_p, div_q;
    logic                      ld_we;
    logic [NW-1:0]             deg_clamp;
    logic [NW-1:0]             wt;
    logic [NW+47:0]            scaled;
    logic signed [48:0]        sum;
    logic signed [48:0]        nx;
    logic signed [48:0]        diff;
    logic signed [47:0]        nx_sat;
    logic [48:0]               diff_mag;

    assign busy  = (r_state != S_IDLE);
    assign ld_we = start && !busy && (i_in.mode == pnrf_pkg::MODE_LOAD)
                   && ({2'b00, i_in.coef_index} <= 8'(MAX_DEGREE));
    assign deg_clamp = ({2'b00, r_degree} > 8'(MAX_DEGREE)) ? NW'(MAX_DEGREE)
                                                              : NW'(r_degree);

    pnrf_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (AW'(i_in.coef_index)),
        .i_wdata (i_in.coef_value),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    pnrf_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_a(r_p), .i_b(r_x), .o_done(mul_done), .o_p(mul_p)
    );

    pnrf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_a(r_p), .i_b(r_d), .o_done(div_done), .o_q(div_q)
    );

    // Derivative weight n - i and the scaled coefficient.
    assign wt     = r_n - r_i;
    assign scaled = pnrf_pkg::mag(ram_rdata) * wt;
    assign sum    = {mul_p[47], mul_p} + {r_term[47], r_term};
    assign nx     = {r_x[47], r_x} - {div_q[47], div_q};
    assign nx_sat = (nx > 49'sd140737488355327) ? pnrf_pkg::Q_MAX :
                    (nx < -49'sd140737488355328) ? pnrf_pkg::Q_MIN : nx[47:0];
    assign diff   = {nx_sat[47], nx_sat} - {r_x[47], r_x};
    assign diff_mag = diff[48] ? (~diff + 1'b1) : diff;

    // Sequencer over Horner steps, division and update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_degree <= pnrf_pkg::DEG_RESET;
            r_eps    <= pnrf_pkg::EPS_RESET;
            r_maxit  <= pnrf_pkg::ITER_RESET;
            o_done   <= 1'b0;
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            o_done   <= 1'b0;
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pnrf_pkg::REG_DEGREE:  r_degree <= i_cfg_data[pnrf_pkg::DEGW-1:0];
                    pnrf_pkg::REG_EPSILON: r_eps    <= i_cfg_data;
                    pnrf_pkg::REG_MAXITER: r_maxit  <= i_cfg_data[pnrf_pkg::ITW-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start && i_in.mode == pnrf_pkg::MODE_SOLVE) begin
                        r_x     <= i_in.x_start;
                        r_n     <= deg_clamp;
                        r_cnt   <= '0;
                        r_state <= S_ITER;
                    end
                end
                // Begin the derivative pass.
                S_ITER: begin
                    r_slope <= 1'b1;
                    r_i     <= '0;
                    r_state <= S_RD;
                end
                S_RD:  r_state <= S_RDW;
                S_RDW: r_state <= S_TERM;
                S_TERM: begin
                    if (r_slope) begin
                        r_term <= pnrf_pkg::from_mag(scaled[48:0] |
                                  {|scaled[NW+47:49], 48'd0}, ram_rdata[47]);
                    end else begin
                        r_term <= ram_rdata;
                    end
                    if (r_i == '0) begin
                        r_state <= S_ADD;
                    end else begin
                        r_mstart <= 1'b1;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_done) r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_i == '0) r_p <= r_term;
                    else r_p <= (sum > 49'sd140737488355327) ? pnrf_pkg::Q_MAX :
                                (sum < -49'sd140737488355328) ? pnrf_pkg::Q_MIN :
                                sum[47:0];
                    if (r_slope && (r_i + 1'b1 >= r_n)) begin
                        // Derivative done; a degree of zero leaves it zero.
                        if (r_n == '0) r_d <= '0;
                        else if (r_i == '0) r_d <= r_term;
                        else r_d <= (sum > 49'sd140737488355327) ? pnrf_pkg::Q_MAX :
                                    (sum < -49'sd140737488355328) ? pnrf_pkg::Q_MIN :
                                    sum[47:0];
                        r_slope <= 1'b0;
                        r_i     <= '0;
                        r_state <= S_DIV;
                    end else if (!r_slope && r_i == r_n) begin
                        r_dstart <= 1'b1;
                        r_state  <= S_DIVW;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RD;
                    end
                end
                // Check the derivative, then start the value pass.
                S_DIV: begin
                    if (r_d == '0) begin
                        r_status <= pnrf_pkg::ST_ZERO_DER;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_DIVW: begin
                    if (div_done) r_state <= S_UPD;
                end
                S_UPD: begin
                    r_x   <= nx_sat;
                    r_cnt <= r_cnt + 1'b1;
                    if (diff_mag < {24'd0, r_eps}) begin
                        r_status <= pnrf_pkg::ST_CONVERGED;
                        r_state  <= S_OUT;
                    end else if (r_cnt + 1'b1 >= ((r_maxit == '0) ? 12'd1 : r_maxit)) begin
                        r_status <= pnrf_pkg::ST_LIMIT;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_ITER;
                    end
                end
                S_OUT: begin
                    o_out.root <= (pnrf_pkg::mag(r_x) < {23'd0, r_eps}) ? '0 : r_x;
                    o_out.iterations <= r_cnt;
                    o_out.status     <= r_status;
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sim/polynomial_newton_root_finder_tb.sv =====
// Self-checking testbench for the Newton-Raphson polynomial root finder.
`timescale 1ns / 100ps

module polynomial_newton_root_finder_tb;

    localparam int IDLE_LIMIT = 2000000;
    localparam longint QMAXL = 64'sh7FFF_FFFF_FFFF;
    localparam longint QMINL = -QMAXL - 1;

    // Tracks coefficients and settings and predicts the result of each solve.
    class root_scoreboard;
        longint    coef_store[64];
        int        degree_reg;
        longint    eps_reg;
        int        iter_limit_reg;
        pnrf_pkg::t_out_beat pending_roots[$];
        int        fail_count;

        function new();
            degree_reg = int'(pnrf_pkg::DEG_RESET);
            eps_reg = longint'(pnrf_pkg::EPS_RESET);
            iter_limit_reg = int'(pnrf_pkg::ITER_RESET);
            fail_count = 0;
            foreach (coef_store[i]) coef_store[i] = 0;
        endfunction

        function void note_config(logic [1:0] idx, logic [pnrf_pkg::EPSW-1:0] data);
            case (idx)
                pnrf_pkg::REG_DEGREE:  degree_reg = int'(data[pnrf_pkg::DEGW-1:0]);
                pnrf_pkg::REG_EPSILON: eps_reg = longint'(data);
                pnrf_pkg::REG_MAXITER: iter_limit_reg = int'(data[pnrf_pkg::ITW-1:0]);
                default: ;
            endcase
        endfunction

        function longint unsigned magnitude(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint signed_clip(longint unsigned m, bit neg);
            if (neg) return (m >= 64'h8000_0000_0000) ? QMINL : -longint'(m);
            return (m > 64'h7FFF_FFFF_FFFF) ? QMAXL : longint'(m);
        endfunction

        function longint clamp(longint v);
            if (v > QMAXL) return QMAXL;
            if (v < QMINL) return QMINL;
            return v;
        endfunction

        function longint fx_mul(longint a, longint b);
            longint unsigned ma, mb, ah, al, bh, bl, hh, m;
            ma = magnitude(a);
            mb = magnitude(b);
            ah = ma >> 24; al = ma & 64'hFFFFFF;
            bh = mb >> 24; bl = mb & 64'hFFFFFF;
            hh = ah * bh;
            if (hh >= (64'd1 << 23)) m = 64'h1_0000_0000_0000;
            else m = (hh << 24) + ah * bl + al * bh + ((al * bl) >> 24);
            return signed_clip(m, (a < 0) != (b < 0));
        endfunction

        function longint fx_div(longint a, longint b);
            longint unsigned num, den, q, r;
            num = magnitude(a);
            den = magnitude(b);
            q = num / den;
            r = num % den;
            if (q >= (64'd1 << 23)) return signed_clip(64'h1_0000_0000_0000, (a < 0) != (b < 0));
            for (int i = 0; i < 24; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 1;
                end
            end
            return signed_clip(q, (a < 0) != (b < 0));
        endfunction

        // Horner evaluation of p(x) over the first n+1 coefficients and of p'(x) over the first n.
        function longint horner_value(longint x, int n);
            longint p;
            p = coef_store[0];
            for (int i = 1; i <= n; i++) p = clamp(fx_mul(p, x) + coef_store[i]);
            return p;
        endfunction

        function longint horner_slope(longint x, int n);
            longint p;
            p = signed_clip(magnitude(coef_store[0]) * n, coef_store[0] < 0);
            for (int i = 1; i < n; i++)
                p = clamp(fx_mul(p, x) + signed_clip(magnitude(coef_store[i]) * (n - i),
                                                     coef_store[i] < 0));
            return p;
        endfunction

        function pnrf_pkg::t_out_beat newton_solve(longint x);
            pnrf_pkg::t_out_beat res;
            int        limit, count;
            longint    d, nx, diff;
            logic [1:0] st;
            limit = (iter_limit_reg == 0) ? 1 : iter_limit_reg;
            count = 0;
            forever begin
                d = horner_slope(x, degree_reg);
                if (d == 0) begin
                    st = pnrf_pkg::ST_ZERO_DER;
                    break;
                end
                nx = clamp(x - fx_div(horner_value(x, degree_reg), d));
                diff = nx - x;
                x = nx;
                count++;
                if (magnitude(diff) < eps_reg) begin
                    st = pnrf_pkg::ST_CONVERGED;
                    break;
                end
                if (count >= limit) begin
                    st = pnrf_pkg::ST_LIMIT;
                    break;
                end
            end
            if (magnitude(x) < eps_reg) x = 0;
            res.root = x[pnrf_pkg::QW-1:0];
            res.iterations = count[pnrf_pkg::ITW-1:0];
            res.status = st;
            return res;
        endfunction

        function void note_input(pnrf_pkg::t_in_beat beat);
            if (beat.mode == pnrf_pkg::MODE_LOAD)
                coef_store[beat.coef_index] = longint'(beat.coef_value);
            else pending_roots.push_back(newton_solve(longint'(beat.x_start)));
        endfunction

        function void check_result(pnrf_pkg::t_out_beat got);
            pnrf_pkg::t_out_beat want;
            if (pending_roots.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                fail_count++;
                return;
            end
            want = pending_roots.pop_front();
            if (got.root !== want.root) begin
                $display("%0t: root expected %h actual %h", $time, want.root, got.root);
                fail_count++;
            end
            if (got.iterations !== want.iterations) begin
                $display("%0t: iterations expected %0d actual %0d", $time,
                         want.iterations, got.iterations);
                fail_count++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                fail_count++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    pnrf_pkg::t_in_beat            i_in = '0;
    logic                          o_done;
    pnrf_pkg::t_out_beat           o_out;
    logic                          i_cfg_we = 1'b0;
    logic [1:0]                    i_cfg_index = '0;
    logic [pnrf_pkg::EPSW-1:0]     i_cfg_data = '0;

    root_scoreboard sb = new();
    int  beats_sent = 0;
    bit  allow_gaps = 1'b1;
    int  idle_cycles = 0;

    polynomial_newton_root_finder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_done(o_done), .o_out(o_out), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watch accepted beats on both sides and stop a hung run.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_input(i_in);
        if (i_rst_n && o_done) sb.check_result(o_out);
        if (i_rst_n && ((start && !busy) || o_done)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one beat and hold it until the block takes it.
    task automatic send_beat(pnrf_pkg::t_in_beat beat);
        @(negedge i_clk);
        start <= 1'b1;
        i_in <= beat;
        do @(posedge i_clk); while (busy);
        beats_sent++;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
        end
    endtask

    task automatic load_coef(int idx, longint val);
        pnrf_pkg::t_in_beat b;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        b = '0;
        b.mode = pnrf_pkg::MODE_LOAD;
        b.coef_index = idx[pnrf_pkg::IDXW-1:0];
        b.coef_value = val[pnrf_pkg::QW-1:0];
        b.x_start = rnd[pnrf_pkg::QW-1:0];
        send_beat(b);
    endtask

    task automatic solve_from(longint x0);
        pnrf_pkg::t_in_beat b;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        b = '0;
        b.mode = pnrf_pkg::MODE_SOLVE;
        b.coef_index = rnd[pnrf_pkg::IDXW-1:0];
        b.coef_value = rnd[pnrf_pkg::QW-1:0];
        b.x_start = x0[pnrf_pkg::QW-1:0];
        send_beat(b);
    endtask

    // Register writes happen only once the block has drained.
    task automatic write_reg(logic [1:0] idx, int unsigned val);
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_roots.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[pnrf_pkg::EPSW-1:0];
        sb.note_config(idx, val[pnrf_pkg::EPSW-1:0]);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic longint rand_q(bit wide);
        logic [63:0] rnd;
        logic [pnrf_pkg::QW-1:0] v;
        if (wide) begin
            rnd = {$urandom, $urandom};
            v = rnd[pnrf_pkg::QW-1:0];
            return longint'($signed(v));
        end
        return longint'($urandom_range(0, 32'h4000_0000)) - 64'sh2000_0000;
    endfunction

    localparam longint ONE = 64'sh100_0000;

    initial begin
        int d;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Degree zero always hits a zero derivative.
        load_coef(0, ONE);
        solve_from(3 * ONE);

        // Linear polynomial, extreme start values, largest limit.
        write_reg(pnrf_pkg::REG_DEGREE, 1);
        write_reg(pnrf_pkg::REG_MAXITER, 4095);
        load_coef(0, 2 * ONE);
        load_coef(1, -3 * ONE);
        solve_from(0);
        solve_from(QMAXL);
        solve_from(QMINL);

        // x^2 + 1 never converges: limit of one and two updates, tightest epsilon.
        write_reg(pnrf_pkg::REG_DEGREE, 2);
        write_reg(pnrf_pkg::REG_EPSILON, 1);
        write_reg(pnrf_pkg::REG_MAXITER, 1);
        load_coef(0, ONE);
        load_coef(1, 0);
        load_coef(2, ONE);
        solve_from(ONE);
        write_reg(pnrf_pkg::REG_MAXITER, 2);
        solve_from(-ONE / 2);

        // x^2 with coarse epsilon snaps a small root to zero; x = 0 has zero slope.
        write_reg(pnrf_pkg::REG_EPSILON, 16777216);
        write_reg(pnrf_pkg::REG_MAXITER, 20);
        load_coef(2, 0);
        solve_from(ONE / 4);
        solve_from(0);

        // Full store at the largest degree.
        write_reg(pnrf_pkg::REG_DEGREE, 63);
        write_reg(pnrf_pkg::REG_MAXITER, 2);
        for (int i = 0; i < 64; i++) load_coef(i, (i == 0) ? QMAXL : rand_q(i % 8 == 1));
        solve_from(ONE / 2);
        solve_from(QMINL);

        // Random phases: fresh settings, well-formed coefficient sets, then mixed beats.
        while (beats_sent < 600) begin
            d = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            write_reg(pnrf_pkg::REG_DEGREE, d);
            case ($urandom_range(0, 3))
                0: write_reg(pnrf_pkg::REG_EPSILON, 1);
                1: write_reg(pnrf_pkg::REG_EPSILON, 16777216);
                default: write_reg(pnrf_pkg::REG_EPSILON, $urandom_range(1, 1 << 20));
            endcase
            write_reg(pnrf_pkg::REG_MAXITER, $urandom_range(1, 30));
            for (int i = 0; i <= d; i++) load_coef(i, rand_q($urandom_range(0, 7) == 0));
            repeat ($urandom_range(8, 24)) begin
                if (beats_sent > 520) allow_gaps = 1'b0;
                if ($urandom_range(0, 2) == 0) load_coef($urandom_range(0, 63),
                                                         rand_q($urandom_range(0, 5) == 0));
                else solve_from(rand_q($urandom_range(0, 7) == 0));
            end
        end

        // Drain and let the block settle.
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_roots.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pnrf_pkg.sv
hdl/pnrf_ram.sv
hdl/pnrf_mul.sv
hdl/pnrf_div.sv
hdl/polynomial_newton_root_finder.sv
sim/polynomial_newton_root_finder_tb.sv
